### sv/drtf_pkg.sv
// shared types and codes for the delimited receive framer
package drtf_pkg;

	// command codes carried on the input channel
	localparam logic [1:0] CMD_RX       = 2'd0;
	localparam logic [1:0] CMD_POP_BYTE = 2'd1;
	localparam logic [1:0] CMD_POP_REC  = 2'd2;

	// status codes carried on the result channel
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_DROP  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// saturation limit of the message length counter
	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	// control sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_OUT
	} state_t;

	// what the pending memory read returns
	typedef enum logic {
		POP_BYTE,
		POP_REC
	} pop_kind_t;

endpackage

### sv/drtf_in_if.sv
// command channel: valid/ready handshake with command payload
interface drtf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  rx_byte;
	logic [63:0] now_ms;

	modport source (output valid, output cmd, output rx_byte, output now_ms, input ready);
	modport sink   (input valid, input cmd, input rx_byte, input now_ms, output ready);
endinterface

### sv/drtf_out_if.sv
// result channel: valid/ready handshake with result payload
interface drtf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  out_byte;
	logic [63:0] rec_time;
	logic [15:0] rec_length;
	logic [7:0]  rec_position;
	logic        record_closed;

	modport source (
		output valid, output status, output out_byte, output rec_time,
		output rec_length, output rec_position, output record_closed, input ready
	);
	modport sink (
		input valid, input status, input out_byte, input rec_time,
		input rec_length, input rec_position, input record_closed, output ready
	);
endinterface

### sv/drtf_ram.sv
// generic single write port ram with registered read
module drtf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/delimited_rx_timestamp_framer_top.sv
// Receive framer for one serial channel. Each command on in_ch yields exactly one result on
// out_ch. A received byte, a pop from an empty store and the ignored command present their
// result the cycle after their transfer; a successful pop of a byte or a record presents it
// only after an extra S_READ state, in which the registered read of the synchronous byte ring
// or record store is loaded into the result register. The next command is taken the cycle
// after the previous result has been transferred, so a stalled result holds off the input.
// Received bytes go into a ring of RING_DEPTH bytes; a delimiter byte or a full ring closes
// the message and pushes a record of (ring head, first-byte timestamp, length) into a FIFO
// of RECORD_DEPTH entries, a record is lost if that FIFO is full. The user must write the
// delimiter through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
module delimited_rx_timestamp_framer_top #(
	parameter int RING_DEPTH   = 256,
	parameter int RECORD_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	drtf_in_if.sink     in_ch,
	drtf_out_if.source  out_ch
);
	import drtf_pkg::*;

	localparam int RING_AW = $clog2(RING_DEPTH);
	localparam int RING_CW = $clog2(RING_DEPTH + 1);
	localparam int REC_AW  = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
	localparam int REC_CW  = $clog2(RECORD_DEPTH + 1);

	state_t state_q, state_d;
	pop_kind_t kind_q;

	logic [7:0]         delim_q;
	logic [RING_AW-1:0] ring_head_q, ring_head_d, ring_tail_q, ring_tail_d;
	logic [RING_CW-1:0] ring_count_q, ring_count_d;
	logic [15:0]        pend_len_q, pend_len_d;
	logic [63:0]        pend_time_q, pend_time_d;
	logic [REC_AW-1:0]  rec_head_q, rec_head_d, rec_tail_q, rec_tail_d;
	logic [REC_CW-1:0]  rec_count_q, rec_count_d;

	// result register
	logic [1:0]  status_q, status_d;
	logic [7:0]  out_byte_q;
	logic [63:0] rec_time_q;
	logic [15:0] rec_length_q;
	logic [7:0]  rec_position_q;
	logic        closed_q, closed_d;

	logic accept;
	logic ring_we, ring_re, rec_we, rec_re, read_go;
	logic closes;
	logic [15:0]        len_inc;
	logic [63:0]        time_lat;
	logic [RING_AW+7:0] head_ext;
	logic [7:0]         ring_rdata;
	logic [63:0]        time_rdata;
	logic [23:0]        lp_rdata;

	assign accept = in_ch.valid && in_ch.ready;

	// command decode and next pointer/counter values
	always_comb begin
		ring_we      = 1'b0;
		ring_re      = 1'b0;
		rec_we       = 1'b0;
		rec_re       = 1'b0;
		closes       = 1'b0;
		status_d     = STAT_OK;
		closed_d     = 1'b0;
		ring_head_d  = ring_head_q;
		ring_tail_d  = ring_tail_q;
		ring_count_d = ring_count_q;
		pend_len_d   = pend_len_q;
		pend_time_d  = pend_time_q;
		rec_head_d   = rec_head_q;
		rec_tail_d   = rec_tail_q;
		rec_count_d  = rec_count_q;
		len_inc      = (pend_len_q == LEN_MAX) ? pend_len_q : pend_len_q + 16'd1;
		time_lat     = (pend_time_q == 64'd0) ? in_ch.now_ms : pend_time_q;
		if (accept) begin
			case (in_ch.cmd)
				CMD_RX: begin
					if (ring_count_q == RING_CW'(RING_DEPTH)) begin
						status_d = STAT_DROP;
					end else begin
						ring_we      = 1'b1;
						ring_head_d  = (ring_head_q == RING_AW'(RING_DEPTH - 1)) ? '0
							: ring_head_q + RING_AW'(1);
						ring_count_d = ring_count_q + RING_CW'(1);
						pend_len_d   = len_inc;
						pend_time_d  = time_lat;
						closes = (in_ch.rx_byte == delim_q)
							|| (ring_count_d == RING_CW'(RING_DEPTH));
						if (closes) begin
							closed_d    = 1'b1;
							pend_len_d  = '0;
							pend_time_d = '0;
							if (rec_count_q != REC_CW'(RECORD_DEPTH)) begin
								rec_we      = 1'b1;
								rec_head_d  = (rec_head_q == REC_AW'(RECORD_DEPTH - 1)) ? '0
									: rec_head_q + REC_AW'(1);
								rec_count_d = rec_count_q + REC_CW'(1);
							end
						end
					end
				end
				CMD_POP_BYTE: begin
					if (ring_count_q == '0) begin
						status_d = STAT_EMPTY;
					end else begin
						ring_re      = 1'b1;
						ring_tail_d  = (ring_tail_q == RING_AW'(RING_DEPTH - 1)) ? '0
							: ring_tail_q + RING_AW'(1);
						ring_count_d = ring_count_q - RING_CW'(1);
					end
				end
				CMD_POP_REC: begin
					if (rec_count_q == '0) begin
						status_d = STAT_EMPTY;
					end else begin
						rec_re      = 1'b1;
						rec_tail_d  = (rec_tail_q == REC_AW'(RECORD_DEPTH - 1)) ? '0
							: rec_tail_q + REC_AW'(1);
						rec_count_d = rec_count_q - REC_CW'(1);
					end
				end
				default: begin
					status_d = STAT_OK;
				end
			endcase
		end
	end

	assign read_go  = ring_re || rec_re;
	assign head_ext = {8'd0, ring_head_d};

	// byte ring and record stores
	drtf_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_head_q),
		.wdata (in_ch.rx_byte),
		.re    (ring_re),
		.raddr (ring_tail_q),
		.rdata (ring_rdata)
	);

	drtf_ram #(.WIDTH(64), .DEPTH(RECORD_DEPTH)) u_rec_time (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_head_q),
		.wdata (time_lat),
		.re    (rec_re),
		.raddr (rec_tail_q),
		.rdata (time_rdata)
	);

	drtf_ram #(.WIDTH(24), .DEPTH(RECORD_DEPTH)) u_rec_lp (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_head_q),
		.wdata ({len_inc, head_ext[7:0]}),
		.re    (rec_re),
		.raddr (rec_tail_q),
		.rdata (lp_rdata)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = read_go ? S_READ : S_OUT;
				end
			end
			S_READ: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ch.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ch.ready  = 1'b0;
		out_ch.valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ch.ready = 1'b1;
			end
			S_OUT: begin
				out_ch.valid = 1'b1;
			end
			default: begin
				in_ch.ready  = 1'b0;
				out_ch.valid = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			delim_q      <= '0;
			ring_head_q  <= '0;
			ring_tail_q  <= '0;
			ring_count_q <= '0;
			pend_len_q   <= '0;
			pend_time_q  <= '0;
			rec_head_q   <= '0;
			rec_tail_q   <= '0;
			rec_count_q  <= '0;
		end else begin
			state_q      <= state_d;
			ring_head_q  <= ring_head_d;
			ring_tail_q  <= ring_tail_d;
			ring_count_q <= ring_count_d;
			pend_len_q   <= pend_len_d;
			pend_time_q  <= pend_time_d;
			rec_head_q   <= rec_head_d;
			rec_tail_q   <= rec_tail_d;
			rec_count_q  <= rec_count_d;
			if (cfg_wr_en) begin
				delim_q <= cfg_wr_data;
			end
		end
	end

	// result register, loaded on transfer or when read data returns
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q       <= status_d;
			closed_q       <= closed_d;
			out_byte_q     <= '0;
			rec_time_q     <= '0;
			rec_length_q   <= '0;
			rec_position_q <= '0;
			kind_q         <= rec_re ? POP_REC : POP_BYTE;
		end else if (state_q == S_READ) begin
			if (kind_q == POP_REC) begin
				rec_time_q     <= time_rdata;
				rec_length_q   <= lp_rdata[23:8];
				rec_position_q <= lp_rdata[7:0];
			end else begin
				out_byte_q <= ring_rdata;
			end
		end
	end

	assign out_ch.status        = status_q;
	assign out_ch.out_byte      = out_byte_q;
	assign out_ch.rec_time      = rec_time_q;
	assign out_ch.rec_length    = rec_length_q;
	assign out_ch.rec_position  = rec_position_q;
	assign out_ch.record_closed = closed_q;

	// ring occupancy never exceeds its depth
	a_ring_count: assert property (@(posedge clk) disable iff (!arst_n)
		ring_count_q <= RING_CW'(RING_DEPTH))
		else $error("ring count above depth");

	// record occupancy never exceeds its depth
	a_rec_count: assert property (@(posedge clk) disable iff (!arst_n)
		rec_count_q <= REC_CW'(RECORD_DEPTH))
		else $error("record count above depth");

	// an empty ring has head and tail together
	a_ring_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(ring_count_q == '0) |-> (ring_head_q == ring_tail_q))
		else $error("empty ring with head and tail apart");

	// no open message means no latched timestamp
	a_pend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_len_q == '0) |-> (pend_time_q == '0))
		else $error("timestamp latched without pending bytes");

	// a memory read is followed by the result being presented
	a_read_out: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && read_go) |=> ##1 out_ch.valid)
		else $error("read result not presented");

endmodule
